// ===== src/rxd_pkg.sv =====
`default_nettype none

package rxd_pkg;

    // Frame geometry
    localparam int MAX_PIXELS  = 4096;
    localparam int STORE_BYTES = (MAX_PIXELS * 3 + 7) / 8;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int FB_W        = $clog2(STORE_BYTES + 1);
    localparam int OFF_W       = $clog2(MAX_PIXELS * 3);

    // Field widths
    localparam int PCNT_W  = 13;
    localparam int BYTE_W  = 8;
    localparam int PIDX_W  = 12;
    localparam int RUN_W   = 7;
    localparam int FRM_W   = 16;
    localparam int CODE_W  = 3;

    // Beat layout
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USED_W = 2 + FRM_W + CODE_W + BYTE_W;

    localparam logic [BYTE_W-1:0] GLYPH_BASE = 8'h91;
    localparam int                KEY_LIT_BIT = 7;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_PXA,
        ST_PXB,
        ST_PXC,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        PH_KEY,
        PH_LIT,
        PH_REP
    } t_phase;

    // Packed bytes per frame, pixel count clamped to 1..MAX_PIXELS
    function automatic logic [FB_W-1:0] f_frame_bytes(input logic [PCNT_W-1:0] p);
        logic [31:0] pc;
        logic [31:0] t;
        pc = 32'(p);
        if (pc < 32'd1) begin
            pc = 32'd1;
        end
        if (pc > 32'(MAX_PIXELS)) begin
            pc = 32'(MAX_PIXELS);
        end
        t = (pc * 32'd3) + 32'd7;
        return FB_W'(t >> 3);
    endfunction

endpackage

`default_nettype wire

// ===== src/rxd_ram.sv =====
`default_nettype none

module rxd_ram #(
    parameter int DEPTH  = 1536,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // single port, read-before-write, registered read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// ===== src/rle_xor_delta_frame_decoder.sv =====
`default_nettype none

// Channel  Dir  Fields (lowest bit first)
// s_axis   in   tuser: req_type | tdata: stream_byte[7:0], pixel_index[19:8]
// m_axis   out  tdata: frame_done[0], overrun[1], frames_decoded[17:2],
//                      pixel_code[20:18], glyph_low_byte[28:21]
// cfg      in   i_cfg_we / i_cfg_wdata: pixel_count, applied on the edge
//
// States after IDLE: key byte FIN; literal byte RD, WR, FIN; repeat value
// byte RD, WR per byte of the clipped run (single store port), FIN; pixel read
// PXA, PXB, PXC, FIN. One beat in flight at a time.
// Reset (synchronous, active low) starts a clearing pass over the 1536-byte
// frame store; s_axis_tready stays low until it ends, config is still taken.
// The result register lets the next beat be taken while a result waits;
// a finished beat holds in FIN until the result register is free.

module rle_xor_delta_frame_decoder (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // stream_byte[7:0], pixel_index[19:8], zero pad above
    input  wire logic [rxd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // req_type[0]
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // frame_done[0], overrun[1], frames_decoded[17:2], pixel_code[20:18],
    // glyph_low_byte[28:21], zero pad above
    output logic      [rxd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  wire logic                             i_cfg_we,
    input  wire logic [rxd_pkg::PCNT_W-1:0]       i_cfg_wdata
);

    import rxd_pkg::*;

    // control state
    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [RUN_W-1:0]    r_run, n_run;
    logic [FB_W-1:0]     r_wp, n_wp;
    logic [FB_W-1:0]     r_fb, n_fb;
    logic [FRM_W-1:0]    r_frames, n_frames;
    logic [ADDR_W-1:0]   r_clr, n_clr;
    logic                r_m_valid, n_m_valid;

    // per-beat payload
    logic [BYTE_W-1:0]   r_byte, n_byte;
    logic [PIDX_W-1:0]   r_idx, n_idx;
    logic                r_over, n_over;
    logic                r_chk, n_chk;   // data byte: check for frame end
    logic [BYTE_W-1:0]   r_lo, n_lo;
    logic [CODE_W-1:0]   r_code, n_code;
    logic [OUT_DATA_W-1:0] r_m_data, n_m_data;

    // store port
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [BYTE_W-1:0]   ram_wdata;
    logic [BYTE_W-1:0]   ram_rdata;

    logic                s_acc;
    logic                out_free;
    logic                fin_done;

    // pixel address
    logic [OFF_W-1:0]    pix_off;
    logic [ADDR_W-1:0]   pix_b0;
    logic [ADDR_W:0]     pix_b1;
    logic                pix_hi_ok;
    logic [2*BYTE_W-1:0] pix_pair;
    logic [2*BYTE_W-1:0] pix_shift;

    // key decode
    logic [RUN_W-1:0]    key_cnt;
    logic [FB_W-1:0]     key_left;
    logic                key_clip;
    logic [RUN_W-1:0]    key_run;

    rxd_ram #(
        .DEPTH (STORE_BYTES),
        .WIDTH (BYTE_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;
    assign fin_done = r_chk && (r_wp >= r_fb);

    assign pix_off   = OFF_W'({r_idx, 1'b0}) + OFF_W'(r_idx);
    assign pix_b0    = ADDR_W'(pix_off >> 3);
    assign pix_b1    = {1'b0, pix_b0} + (ADDR_W + 1)'(1);
    assign pix_hi_ok = (pix_b1 < (ADDR_W + 1)'(STORE_BYTES));
    assign pix_pair  = {(pix_hi_ok ? ram_rdata : '0), r_lo};
    assign pix_shift = pix_pair >> pix_off[2:0];

    assign key_cnt  = s_axis_tdata[RUN_W-1:0];
    assign key_left = (r_wp < r_fb) ? (r_fb - r_wp) : '0;
    assign key_clip = (FB_W'(key_cnt) > key_left);
    assign key_run  = key_clip ? RUN_W'(key_left) : key_cnt;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == ADDR_W'(STORE_BYTES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_axis_tuser) begin
                        n_state = ST_PXA;
                    end else if (r_phase == PH_LIT) begin
                        n_state = ST_RD;
                    end else if (r_phase == PH_REP && r_run != '0) begin
                        n_state = ST_RD;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_RD:  n_state = ST_WR;
            ST_WR: begin
                if (r_phase == PH_REP && r_run != RUN_W'(1)) begin
                    n_state = ST_RD;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_PXA: n_state = ST_PXB;
            ST_PXB: n_state = ST_PXC;
            ST_PXC: n_state = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // outputs: handshake and store port
    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = ADDR_W'(r_wp);
        ram_wdata     = ram_rdata ^ r_byte;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = '0;
            end
            ST_IDLE: s_axis_tready = 1'b1;
            ST_RD:   ram_addr = ADDR_W'(r_wp);
            ST_WR:   ram_we   = 1'b1;
            ST_PXA:  ram_addr = pix_b0;
            ST_PXB:  ram_addr = pix_hi_ok ? ADDR_W'(pix_b1) : pix_b0;
            default: ram_we   = 1'b0;
        endcase
    end

    // datapath
    always_comb begin
        n_phase   = r_phase;
        n_run     = r_run;
        n_wp      = r_wp;
        n_fb      = r_fb;
        n_frames  = r_frames;
        n_clr     = r_clr;
        n_m_valid = r_m_valid;
        n_byte    = r_byte;
        n_idx     = r_idx;
        n_over    = r_over;
        n_chk     = r_chk;
        n_lo      = r_lo;
        n_code    = r_code;
        n_m_data  = r_m_data;

        if (m_axis_tvalid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: n_clr = r_clr + ADDR_W'(1);
            ST_IDLE: begin
                if (s_acc) begin
                    n_byte = s_axis_tdata[BYTE_W-1:0];
                    n_idx  = s_axis_tdata[BYTE_W +: PIDX_W];
                    n_over = 1'b0;
                    n_chk  = 1'b0;
                    n_code = '0;
                    if (!s_axis_tuser) begin
                        case (r_phase)
                            PH_KEY: begin
                                n_over = key_clip;
                                n_run  = key_run;
                                if (s_axis_tdata[KEY_LIT_BIT]) begin
                                    n_phase = (key_run == '0) ? PH_KEY : PH_LIT;
                                end else begin
                                    n_phase = PH_REP;
                                end
                            end
                            PH_LIT: n_chk = 1'b1;
                            PH_REP: begin
                                n_chk = 1'b1;
                                if (r_run == '0) begin
                                    n_phase = PH_KEY;
                                end
                            end
                            default: n_phase = PH_KEY;
                        endcase
                    end
                end
            end
            ST_WR: begin
                n_wp  = r_wp + FB_W'(1);
                n_run = r_run - RUN_W'(1);
                if (r_run == RUN_W'(1)) begin
                    n_phase = PH_KEY;
                end
            end
            ST_PXB: n_lo   = ram_rdata;
            ST_PXC: n_code = pix_shift[CODE_W-1:0];
            ST_FIN: begin
                if (out_free) begin
                    if (fin_done) begin
                        n_wp     = '0;
                        n_phase  = PH_KEY;
                        n_run    = '0;
                        n_frames = r_frames + FRM_W'(1);
                    end
                    n_m_valid = 1'b1;
                    n_m_data  = OUT_DATA_W'({GLYPH_BASE + BYTE_W'(r_code), r_code,
                                             n_frames, r_over, fin_done});
                end
            end
            default: n_chk = r_chk;
        endcase

        // pixel count write restarts decoding; store and counter kept
        if (i_cfg_we) begin
            n_fb    = f_frame_bytes(i_cfg_wdata);
            n_phase = PH_KEY;
            n_run   = '0;
            n_wp    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_phase   <= PH_KEY;
            r_run     <= '0;
            r_wp      <= '0;
            r_fb      <= FB_W'(STORE_BYTES);
            r_frames  <= '0;
            r_clr     <= '0;
            r_m_valid <= 1'b0;
            r_chk     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_run     <= n_run;
            r_wp      <= n_wp;
            r_fb      <= n_fb;
            r_frames  <= n_frames;
            r_clr     <= n_clr;
            r_m_valid <= n_m_valid;
            r_chk     <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte   <= n_byte;
        r_idx    <= n_idx;
        r_over   <= n_over;
        r_lo     <= n_lo;
        r_code   <= n_code;
        r_m_data <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire

// ===== src/rxd_checker.sv =====
`default_nettype none

module rxd_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [rxd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    import rxd_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat changed while stalled");

    // one beat in flight: no accept on the cycle after an accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while previous beat still in work");

    // glyph byte tracks pixel code
    a_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[28:21] ==
                           (GLYPH_BASE + BYTE_W'(m_axis_tdata[20:18]))))
        else $error("glyph byte does not match pixel code");

    // key beats flag overrun, data beats flag frame end, never both
    a_done_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("frame_done and overrun set together");

endmodule

bind rle_xor_delta_frame_decoder rxd_checker u_rxd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

// Checks the RLE / XOR-delta frame decoder against a cycle-free predictor.
// A short directed part hits the clip, zero-count and run-boundary cases.
// Random phases follow, each at a new pixel count, with random gaps on both
// sides and one long sink hold-off to back the decoder up.
module testbench;
    import rxd_pkg::*;

    localparam int WATCHDOG_LIMIT = 8000;  // clearing pass + long hold-off + longest repeat
    localparam int STALL_CYCLES   = 400;
    localparam int TAIL_CYCLES    = 300;   // longest beat is a 127-byte repeat

    localparam logic       REQ_STREAM  = 1'b0;
    localparam logic       REQ_READ    = 1'b1;
    localparam logic [7:0] KEY_LITERAL = 8'h80;
    localparam logic [7:0] KEY_REPEAT  = 8'h00;

    // tuser: req_type | tdata: stream_byte, pixel_index
    typedef struct packed {
        logic              req_type;
        logic [PIDX_W-1:0] pixel_index;
        logic [BYTE_W-1:0] stream_byte;
    } t_beat;

    // Same layout as m_axis_tdata, lowest field last
    typedef struct packed {
        logic [OUT_DATA_W-OUT_USED_W-1:0] pad;
        logic [BYTE_W-1:0]                glyph_low_byte;
        logic [CODE_W-1:0]                pixel_code;
        logic [FRM_W-1:0]                 frames_decoded;
        logic                             overrun;
        logic                             frame_done;
    } t_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;  // stream_byte[7:0], pixel_index[19:8]
    logic                    s_axis_tuser = 1'b0; // req_type[0]
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;        // done, overrun, frames, code, glyph
    logic                    i_cfg_we = 1'b0;
    logic [PCNT_W-1:0]       i_cfg_wdata = '0;

    rle_xor_delta_frame_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Decoder model state
    // ------------------------------------------------------------------
    logic [PCNT_W-1:0] pix_count = PCNT_W'(MAX_PIXELS);
    t_phase            dec_phase = PH_KEY;
    logic [RUN_W-1:0]  run_left  = '0;
    int                wr_pos    = 0;
    logic [FRM_W-1:0]  frame_ctr = '0;
    logic [7:0]        pix_store [STORE_BYTES];

    // Beats waiting to go out, and results the decoder still owes us
    t_beat   pending_q[$];
    t_result delta_q[$];

    int n_pushed = 0, n_accepted = 0, n_results = 0, n_errors = 0;
    int n_reads = 0, n_frames = 0, n_clipped = 0, n_settings = 1;
    int snd_idle_pct = 0, rcv_idle_pct = 0;
    bit stall_req = 1'b0;
    int stall_left = 0;
    int quiet_cycles = 0;

    t_beat   on_bus;
    t_result got, want;

    // Packed bytes per frame; count clamped to 1..MAX_PIXELS
    function automatic int frame_len(int p);
        if (p < 1) p = 1;
        if (p > MAX_PIXELS) p = MAX_PIXELS;
        return (p * 3 + 7) / 8;
    endfunction

    function automatic void put_byte(logic [7:0] v);
        if (wr_pos < STORE_BYTES) pix_store[wr_pos] ^= v;
        wr_pos++;
    endfunction

    // Frame boundary: wrap the write pointer and bump the frame count
    function automatic bit end_of_frame(int fb);
        if (wr_pos < fb) return 1'b0;
        wr_pos    = 0;
        dec_phase = PH_KEY;
        run_left  = '0;
        frame_ctr = frame_ctr + 1'b1;
        return 1'b1;
    endfunction

    // Apply one beat to the model and return the result it should produce
    function automatic t_result decode_beat(t_beat b);
        t_result r;
        int fb, room, cnt, off;
        r  = '0;
        fb = frame_len(pix_count);
        if (b.req_type == REQ_READ) begin
            off = b.pixel_index * 3;
            for (int j = 0; j < CODE_W; j++) begin
                r.pixel_code[j] = pix_store[(off + j) >> 3][(off + j) & 7];
            end
        end else begin
            case (dec_phase)
                PH_LIT: begin
                    put_byte(b.stream_byte);
                    run_left = run_left - 1'b1;
                    if (run_left == 0) dec_phase = PH_KEY;
                    r.frame_done = end_of_frame(fb);
                end
                PH_REP: begin
                    // value byte fans out over the whole clipped run
                    repeat (run_left) put_byte(b.stream_byte);
                    run_left  = '0;
                    dec_phase = PH_KEY;
                    r.frame_done = end_of_frame(fb);
                end
                default: begin
                    cnt  = int'(b.stream_byte[RUN_W-1:0]);
                    room = (wr_pos < fb) ? fb - wr_pos : 0;
                    if (cnt > room) begin
                        cnt       = room;
                        r.overrun = 1'b1;
                    end
                    run_left = RUN_W'(cnt);
                    if (b.stream_byte[KEY_LIT_BIT]) begin
                        dec_phase = (cnt == 0) ? PH_KEY : PH_LIT;
                    end else begin
                        dec_phase = PH_REP;
                    end
                end
            endcase
        end
        r.frames_decoded = frame_ctr;
        r.glyph_low_byte = GLYPH_BASE + BYTE_W'(r.pixel_code);
        return r;
    endfunction

    task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Source side: present queued beats, random gaps between them
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                delta_q.push_back(decode_beat(on_bus));
                n_accepted++;
                if (on_bus.req_type == REQ_READ) n_reads++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
                    on_bus = pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_DATA_W'({on_bus.pixel_index, on_bus.stream_byte});
                    s_axis_tuser  <= on_bus.req_type;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sink side: check each result beat, random back-pressure, and one
    // long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata);
                if (delta_q.size() == 0) begin
                    $error("result beat 0x%0h with nothing outstanding", m_axis_tdata);
                    n_errors++;
                end else begin
                    want = delta_q.pop_front();
                    cmp_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
                    cmp_field("overrun", 32'(want.overrun), 32'(got.overrun));
                    cmp_field("frames_decoded", 32'(want.frames_decoded),
                              32'(got.frames_decoded));
                    cmp_field("pixel_code", 32'(want.pixel_code), 32'(got.pixel_code));
                    cmp_field("glyph_low_byte", 32'(want.glyph_low_byte),
                              32'(got.glyph_low_byte));
                    n_frames  += int'(want.frame_done);
                    n_clipped += int'(want.overrun);
                    n_results++;
                end
            end
            if (stall_req) begin
                stall_left = STALL_CYCLES;
                stall_req  = 1'b0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // Watchdog: long stretch with no beat moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_beat(logic rt, logic [7:0] sb, logic [PIDX_W-1:0] idx);
        t_beat b;
        b.req_type    = rt;
        b.stream_byte = sb;
        b.pixel_index = idx;
        pending_q.push_back(b);
        n_pushed++;
    endtask

    task automatic push_byte(logic [7:0] sb);
        push_beat(REQ_STREAM, sb, PIDX_W'($urandom));
    endtask

    task automatic push_read(logic [PIDX_W-1:0] idx);
        push_beat(REQ_READ, 8'($urandom), idx);
    endtask

    // Every beat answered and nothing in flight
    task automatic drain();
        wait (n_results == n_pushed);
        @(posedge i_clk);
    endtask

    task automatic set_pixel_count(logic [PCNT_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        // register write restarts the decode at byte zero
        pix_count = v;
        dec_phase = PH_KEY;
        run_left  = '0;
        wr_pos    = 0;
        n_settings++;
    endtask

    // Mostly well-formed runs sized to the frame, some oversized ones,
    // reads sprinkled in (also inside literal runs) and stray bytes.
    task automatic random_frames(int pc, int n_beats, int lit_pct);
        int first, gfb, gpos, cnt, cmax, keep, lim;
        set_pixel_count(PCNT_W'(pc));
        first = n_pushed;
        gfb   = frame_len(pc);
        gpos  = 0;
        lim   = (pc < 1) ? 1 : (pc > MAX_PIXELS) ? MAX_PIXELS : pc;
        while (n_pushed - first < n_beats) begin
            case ($urandom_range(99)) inside
                [0:17]:  push_read(PIDX_W'($urandom_range(1) ? $urandom_range(lim - 1)
                                                     : $urandom_range(MAX_PIXELS - 1)));
                [18:21]: push_byte(8'($urandom));
                default: begin
                    cmax = (gfb - gpos < 127) ? gfb - gpos : 127;
                    cnt  = ($urandom_range(9) == 0) ? $urandom_range(127)
                                                    : $urandom_range(cmax);
                    keep = (cnt < gfb - gpos) ? cnt : gfb - gpos;
                    if ($urandom_range(99) < lit_pct) begin
                        push_byte(KEY_LITERAL | 8'(cnt));
                        repeat (keep) begin
                            if ($urandom_range(9) == 0) begin
                                push_read(PIDX_W'($urandom_range(lim - 1)));
                            end
                            push_byte(8'($urandom));
                        end
                    end else begin
                        push_byte(KEY_REPEAT | 8'(cnt));
                        push_byte(8'($urandom));
                    end
                    gpos += keep;
                    if (gpos >= gfb) gpos = 0;
                end
            endcase
        end
    endtask

    initial begin
        foreach (pix_store[i]) pix_store[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Busy source, sparse sink
        snd_idle_pct = 12;
        rcv_idle_pct = 72;

        // Full-size frame straight out of reset
        push_read(0);
        push_read(PIDX_W'(MAX_PIXELS - 1));
        push_byte(KEY_REPEAT | 8'd127);
        push_byte(8'hFF);
        push_read(338);                     // pixel straddles two store bytes
        push_byte(KEY_LITERAL | 8'd0);      // empty literal
        push_byte(KEY_REPEAT | 8'd0);       // empty repeat still eats its value
        push_byte(8'hA5);
        push_byte(KEY_LITERAL | 8'd3);
        push_byte(8'h00);
        push_read(339);                     // read in the middle of a literal
        push_byte(8'h5A);
        push_byte(8'hFF);

        // Tiny frame: two packed bytes, runs clip at the frame end
        set_pixel_count(5);
        push_byte(KEY_LITERAL | 8'd5);
        push_byte(8'h12);
        push_byte(8'h34);
        push_byte(KEY_REPEAT | 8'd127);
        push_byte(8'hC3);
        push_byte(KEY_LITERAL | 8'd1);
        push_byte(8'h0F);
        push_byte(KEY_LITERAL | 8'd3);      // only one byte left, clipped
        push_byte(8'h55);
        push_byte(8'hFF);                   // excess byte becomes the next key
        push_byte(8'h00);
        push_byte(8'h01);
        push_read(4);                       // last pixel of the frame
        push_read(5);                       // beyond it: stale data from before

        random_frames(1, 300, 50);
        random_frames(0, 250, 50);          // zero clamps to one pixel
        random_frames(37, 300, 40);

        // Sparse source, busy sink
        snd_idle_pct = 72;
        rcv_idle_pct = 12;
        random_frames(8191, 330, 15);       // above range clamps to full size
        random_frames(MAX_PIXELS, 300, 15);

        // Flat out, with one long sink hold-off so the input backs up
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        stall_req = 1'b1;
        random_frames(MAX_PIXELS - 1, 300, 15);
        random_frames(13, 150, 50);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d beats (%0d pixel reads) over %0d pixel-count settings;",
                 n_accepted, n_reads, n_settings);
        $display("%0d results checked, %0d frames completed, %0d clipped runs.",
                 n_results, n_frames, n_clipped);
        if (n_errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
